FILE: src/mddr_pkg.sv
// ---------------------------------------------------------------------------
// Disk register block package
// Shared widths, register offsets, command codes and the request and
// response structs that pass between the top level and the register file.
// ---------------------------------------------------------------------------
package mddr_pkg;

  // Default number of emulated drives.
  localparam int DRIVE_COUNT_DEF = 16;

  // Field widths.
  localparam int OFF_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int SECTOR_W = 32;
  localparam int DMA_W    = 24;
  localparam int SIZE_W   = 2;
  localparam int BYTES_W  = 18;
  localparam int DRVSEL_W = 4;

  // Bus access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register offsets.
  localparam logic [OFF_W-1:0] OFF_SEC3   = 4'd0;
  localparam logic [OFF_W-1:0] OFF_SEC2   = 4'd1;
  localparam logic [OFF_W-1:0] OFF_SEC1   = 4'd2;
  localparam logic [OFF_W-1:0] OFF_SEC0   = 4'd3;
  localparam logic [OFF_W-1:0] OFF_DMA2   = 4'd4;
  localparam logic [OFF_W-1:0] OFF_DMA1   = 4'd5;
  localparam logic [OFF_W-1:0] OFF_DMA0   = 4'd6;
  localparam logic [OFF_W-1:0] OFF_COUNT  = 4'd7;
  localparam logic [OFF_W-1:0] OFF_STATUS = 4'd8;

  // Command codes written to the status offset.
  localparam logic [BYTE_W-1:0] CMD_SELECT_LAST = 8'h0F;
  localparam logic [BYTE_W-1:0] CMD_SIZE_FIRST  = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_SIZE_LAST   = 8'h13;
  localparam logic [BYTE_W-1:0] CMD_READ        = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_CLEAR_ERROR = 8'h80;

  // Status byte bits.
  localparam logic [BYTE_W-1:0] STATUS_WRITABLE = 8'h40;

  // Reset values of the per-drive registers.
  localparam logic [SIZE_W-1:0] SIZE_RESET  = 2'd2;
  localparam logic [BYTE_W-1:0] COUNT_RESET = 8'd1;

  // Log2 of the smallest sector size (128 bytes).
  localparam int SIZE_BASE_LOG = 7;

  // One bus access.
  typedef struct packed {
    logic              opcode;
    logic [OFF_W-1:0]  reg_offset;
    logic [BYTE_W-1:0] write_byte;
    logic              media_fail;
  } req_t;

  // The result of one bus access.
  typedef struct packed {
    logic [BYTE_W-1:0]   read_byte;
    logic                xfer_valid;
    logic [SECTOR_W-1:0] xfer_sector;
    logic [DMA_W-1:0]    xfer_dma_addr;
    logic [BYTES_W-1:0]  xfer_bytes;
  } rsp_t;

endpackage

FILE: src/mddr_regfile.sv
// ---------------------------------------------------------------------------
// Disk register file
// Holds the per-drive registers and the selected drive. Computes the
// response of one request combinationally and commits the state change
// when the request is retired.
// ---------------------------------------------------------------------------
module mddr_regfile #(
  parameter int DRIVE_COUNT = mddr_pkg::DRIVE_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  mddr_pkg::req_t req,
  input  logic           commit,
  output mddr_pkg::rsp_t rsp
);

  localparam int DRV_W = (DRIVE_COUNT > 1) ? $clog2(DRIVE_COUNT) : 1;

  logic [mddr_pkg::DRVSEL_W-1:0] active_drive;
  logic [mddr_pkg::SECTOR_W-1:0] sector_numbers [DRIVE_COUNT];
  logic [mddr_pkg::DMA_W-1:0]    dma_addresses  [DRIVE_COUNT];
  logic [mddr_pkg::SIZE_W-1:0]   size_codes     [DRIVE_COUNT];
  logic [mddr_pkg::BYTE_W-1:0]   sector_counts  [DRIVE_COUNT];
  logic                          error_flags    [DRIVE_COUNT];

  logic [DRV_W-1:0]              drv;
  logic [mddr_pkg::SECTOR_W-1:0] sec_cur;
  logic [mddr_pkg::DMA_W-1:0]    dma_cur;
  logic [mddr_pkg::SIZE_W-1:0]   size_cur;
  logic [mddr_pkg::BYTE_W-1:0]   cnt_cur;
  logic                          err_cur;

  logic [mddr_pkg::DRVSEL_W-1:0] active_drive_next;
  logic [mddr_pkg::SECTOR_W-1:0] sec_next;
  logic [mddr_pkg::DMA_W-1:0]    dma_next;
  logic [mddr_pkg::SIZE_W-1:0]   size_next;
  logic [mddr_pkg::BYTE_W-1:0]   cnt_next;
  logic                          err_next;

  logic [mddr_pkg::BYTES_W-1:0]  xfer_len;
  logic                          is_write;
  logic [mddr_pkg::BYTE_W-1:0]   wb;

  // The selected drive is always below the drive count, so it indexes directly.
  assign drv      = active_drive[DRV_W-1:0];
  assign sec_cur  = sector_numbers[drv];
  assign dma_cur  = dma_addresses[drv];
  assign size_cur = size_codes[drv];
  assign cnt_cur  = sector_counts[drv];
  assign err_cur  = error_flags[drv];
  assign is_write = (req.opcode == mddr_pkg::OP_WRITE);
  assign wb       = req.write_byte;

  // Transfer length is the sector count scaled by the sector size.
  assign xfer_len = {{(mddr_pkg::BYTES_W - mddr_pkg::BYTE_W){1'b0}}, cnt_cur}
                    << ({3'd0, size_cur} + 5'(mddr_pkg::SIZE_BASE_LOG));

  // Response and next state of the selected drive.
  always_comb begin
    rsp               = '0;
    active_drive_next = active_drive;
    sec_next          = sec_cur;
    dma_next          = dma_cur;
    size_next         = size_cur;
    cnt_next          = cnt_cur;
    err_next          = err_cur;
    if (!is_write) begin
      case (req.reg_offset)
        mddr_pkg::OFF_SEC3:   rsp.read_byte = sec_cur[31:24];
        mddr_pkg::OFF_SEC2:   rsp.read_byte = sec_cur[23:16];
        mddr_pkg::OFF_SEC1:   rsp.read_byte = sec_cur[15:8];
        mddr_pkg::OFF_SEC0:   rsp.read_byte = sec_cur[7:0];
        mddr_pkg::OFF_DMA2:   rsp.read_byte = dma_cur[23:16];
        mddr_pkg::OFF_DMA1:   rsp.read_byte = dma_cur[15:8];
        mddr_pkg::OFF_DMA0:   rsp.read_byte = dma_cur[7:0];
        mddr_pkg::OFF_COUNT:  rsp.read_byte = cnt_cur;
        mddr_pkg::OFF_STATUS: rsp.read_byte = {err_cur, 1'b0, size_cur, active_drive}
                                              | mddr_pkg::STATUS_WRITABLE;
        default:              rsp.read_byte = '0;
      endcase
    end else begin
      case (req.reg_offset)
        mddr_pkg::OFF_SEC3:   sec_next[31:24] = wb;
        mddr_pkg::OFF_SEC2:   sec_next[23:16] = wb;
        mddr_pkg::OFF_SEC1:   sec_next[15:8]  = wb;
        mddr_pkg::OFF_SEC0:   sec_next[7:0]   = wb;
        mddr_pkg::OFF_DMA2:   dma_next[23:16] = wb;
        mddr_pkg::OFF_DMA1:   dma_next[15:8]  = wb;
        mddr_pkg::OFF_DMA0:   dma_next[7:0]   = wb;
        mddr_pkg::OFF_COUNT:  cnt_next        = wb;
        mddr_pkg::OFF_STATUS: begin
          // Command decode.
          if (wb <= mddr_pkg::CMD_SELECT_LAST) begin
            if (32'(wb) < 32'(DRIVE_COUNT)) begin
              active_drive_next = wb[mddr_pkg::DRVSEL_W-1:0];
            end
          end else if (wb inside {[mddr_pkg::CMD_SIZE_FIRST:mddr_pkg::CMD_SIZE_LAST]}) begin
            size_next = wb[mddr_pkg::SIZE_W-1:0];
          end else if (wb == mddr_pkg::CMD_READ) begin
            // A zero count issues nothing and leaves the drive alone.
            if (cnt_cur != '0) begin
              rsp.xfer_valid    = 1'b1;
              rsp.xfer_sector   = sec_cur;
              rsp.xfer_dma_addr = dma_cur;
              rsp.xfer_bytes    = xfer_len;
              if (req.media_fail) begin
                err_next = 1'b1;
              end
              sec_next = sec_cur + {{(mddr_pkg::SECTOR_W - mddr_pkg::BYTE_W){1'b0}}, cnt_cur};
              dma_next = dma_cur + {{(mddr_pkg::DMA_W - mddr_pkg::BYTES_W){1'b0}}, xfer_len};
            end
          end else if (wb == mddr_pkg::CMD_CLEAR_ERROR) begin
            err_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Commit the selected drive's registers when the request retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_drive <= '0;
      for (int i = 0; i < DRIVE_COUNT; i++) begin
        sector_numbers[i] <= '0;
        dma_addresses[i]  <= '0;
        size_codes[i]     <= mddr_pkg::SIZE_RESET;
        sector_counts[i]  <= mddr_pkg::COUNT_RESET;
        error_flags[i]    <= 1'b0;
      end
    end else if (commit) begin
      active_drive        <= active_drive_next;
      sector_numbers[drv] <= sec_next;
      dma_addresses[drv]  <= dma_next;
      size_codes[drv]     <= size_next;
      sector_counts[drv]  <= cnt_next;
      error_flags[drv]    <= err_next;
    end
  end

endmodule

FILE: src/multi_drive_disk_register_block.sv
// ---------------------------------------------------------------------------
// Multi-drive disk register block
// Byte-wide bus register block for a set of emulated disk drives. Each bus
// request reads or writes one register of the selected drive or issues a
// command; a read command produces a transfer request.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid, in_stall  | opcode, reg_offset, write_byte,
//           |                     | media_fail
//   out     | out_valid, out_stall| read_byte, xfer_valid, xfer_sector,
//           |                     | xfer_dma_addr, xfer_bytes
//
// One request is taken per cycle while in_stall is low. A request waits in the
// input register while its response is computed, and the drive state is
// updated as it moves into the result register, which drives the outputs.
// Reset clears the selected drive and sets every drive to its default.
// A stall on the output holds the result register and, while both
// registers are full, stalls the input.
// ---------------------------------------------------------------------------
module multi_drive_disk_register_block #(
  parameter int DRIVE_COUNT = mddr_pkg::DRIVE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [mddr_pkg::OFF_W-1:0]    reg_offset,
  input  logic [mddr_pkg::BYTE_W-1:0]   write_byte,
  input  logic                          media_fail,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mddr_pkg::BYTE_W-1:0]   read_byte,
  output logic                          xfer_valid,
  output logic [mddr_pkg::SECTOR_W-1:0] xfer_sector,
  output logic [mddr_pkg::DMA_W-1:0]    xfer_dma_addr,
  output logic [mddr_pkg::BYTES_W-1:0]  xfer_bytes
);

  logic           req_valid;
  mddr_pkg::req_t req;
  logic           rsp_valid;
  mddr_pkg::rsp_t rsp;
  mddr_pkg::rsp_t rsp_comb;
  logic           rsp_free;
  logic           commit;
  logic           in_take;

  // Pipeline flow control.
  assign rsp_free = !rsp_valid || !out_stall;
  assign commit   = req_valid && rsp_free;
  assign in_stall = req_valid && !rsp_free;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_take) begin
      req_valid <= 1'b1;
    end else if (commit) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req.opcode     <= opcode;
      req.reg_offset <= reg_offset;
      req.write_byte <= write_byte;
      req.media_fail <= media_fail;
    end
  end

  // Register file and request decode.
  mddr_regfile #(
    .DRIVE_COUNT(DRIVE_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .commit (commit),
    .rsp    (rsp_comb)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp <= rsp_comb;
    end
  end

  assign out_valid     = rsp_valid;
  assign read_byte     = rsp.read_byte;
  assign xfer_valid    = rsp.xfer_valid;
  assign xfer_sector   = rsp.xfer_sector;
  assign xfer_dma_addr = rsp.xfer_dma_addr;
  assign xfer_bytes    = rsp.xfer_bytes;

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// Disk register block regression bench
// Drives bus requests into the disk register block under random sender gaps
// and receiver stalls, expects each response from the directed table or as
// predicted by a private copy of the per-drive registers, and compares each response field by field in order.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mddr_pkg::*;

  localparam int NDRIVES      = DRIVE_COUNT_DEF;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 64;
  localparam int TAIL_CYCLES  = 8;
  localparam int LIMIT_NS     = 3_000_000;

  // Command and offset codes that the package does not name.
  localparam logic [BYTE_W-1:0] CMD_SELECT_FIRST  = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_UNUSED        = 8'hFF;
  localparam logic [OFF_W-1:0]  OFF_UNMAPPED_FIRST = 4'd9;
  localparam logic [OFF_W-1:0]  OFF_UNMAPPED_LAST  = 4'd15;

  typedef enum int {RX_FLOW, RX_COIN, RX_EVERY_THIRD, RX_MOSTLY_STALLED, RX_HOLD} rx_mode_e;

  typedef struct {
    req_t rq;
    bit   known;
    rsp_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                opcode = OP_READ;
  logic [OFF_W-1:0]    reg_offset = '0;
  logic [BYTE_W-1:0]   write_byte = '0;
  logic                media_fail = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   read_byte;
  logic                xfer_valid;
  logic [SECTOR_W-1:0] xfer_sector;
  logic [DMA_W-1:0]    xfer_dma_addr;
  logic [BYTES_W-1:0]  xfer_bytes;

  // Private copy of the drive registers, advanced on every accepted request.
  logic [DRVSEL_W-1:0] sel_drive = '0;
  logic [SECTOR_W-1:0] drv_sector [NDRIVES] = '{default: '0};
  logic [DMA_W-1:0]    drv_dma    [NDRIVES] = '{default: '0};
  logic [SIZE_W-1:0]   drv_size   [NDRIVES] = '{default: SIZE_RESET};
  logic [BYTE_W-1:0]   drv_count  [NDRIVES] = '{default: COUNT_RESET};
  logic                drv_err    [NDRIVES] = '{default: 1'b0};

  rsp_t      pending_rsp[$];
  plan_row_t directed_plan[$];
  req_t      job_q[$];

  int  n_errors    = 0;
  int  n_sent      = 0;
  int  n_random    = 0;
  int  n_xfer      = 0;
  int  burst_left  = 0;
  logic long_hold   = 1'b0;
  logic hold_wanted = 1'b0;

  multi_drive_disk_register_block u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .reg_offset    (reg_offset),
    .write_byte    (write_byte),
    .media_fail    (media_fail),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_byte     (read_byte),
    .xfer_valid    (xfer_valid),
    .xfer_sector   (xfer_sector),
    .xfer_dma_addr (xfer_dma_addr),
    .xfer_bytes    (xfer_bytes)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Response of one bus access; updates the private drive registers.
  function automatic rsp_t disk_regs_access(input req_t r);
    rsp_t                o;
    logic [DRVSEL_W-1:0] d;
    logic [BYTES_W-1:0]  nbytes;
    o = '0;
    d = sel_drive;
    if (r.opcode == OP_READ) begin
      case (r.reg_offset)
        OFF_SEC3:   o.read_byte = drv_sector[d][31:24];
        OFF_SEC2:   o.read_byte = drv_sector[d][23:16];
        OFF_SEC1:   o.read_byte = drv_sector[d][15:8];
        OFF_SEC0:   o.read_byte = drv_sector[d][7:0];
        OFF_DMA2:   o.read_byte = drv_dma[d][23:16];
        OFF_DMA1:   o.read_byte = drv_dma[d][15:8];
        OFF_DMA0:   o.read_byte = drv_dma[d][7:0];
        OFF_COUNT:  o.read_byte = drv_count[d];
        OFF_STATUS: o.read_byte = {drv_err[d], 1'b0, drv_size[d], sel_drive} | STATUS_WRITABLE;
        default:    o.read_byte = '0;
      endcase
    end else begin
      case (r.reg_offset)
        OFF_SEC3:  drv_sector[d][31:24] = r.write_byte;
        OFF_SEC2:  drv_sector[d][23:16] = r.write_byte;
        OFF_SEC1:  drv_sector[d][15:8]  = r.write_byte;
        OFF_SEC0:  drv_sector[d][7:0]   = r.write_byte;
        OFF_DMA2:  drv_dma[d][23:16]    = r.write_byte;
        OFF_DMA1:  drv_dma[d][15:8]     = r.write_byte;
        OFF_DMA0:  drv_dma[d][7:0]      = r.write_byte;
        OFF_COUNT: drv_count[d]         = r.write_byte;
        OFF_STATUS: begin
          // A write to the status offset is a command.
          if (r.write_byte <= CMD_SELECT_LAST) begin
            sel_drive = r.write_byte[DRVSEL_W-1:0];
          end else if (r.write_byte >= CMD_SIZE_FIRST && r.write_byte <= CMD_SIZE_LAST) begin
            drv_size[d] = r.write_byte[SIZE_W-1:0];
          end else if (r.write_byte == CMD_READ && drv_count[d] != '0) begin
            nbytes          = BYTES_W'(drv_count[d]) << (drv_size[d] + SIZE_BASE_LOG);
            o.xfer_valid    = 1'b1;
            o.xfer_sector   = drv_sector[d];
            o.xfer_dma_addr = drv_dma[d];
            o.xfer_bytes    = nbytes;
            if (r.media_fail) drv_err[d] = 1'b1;
            drv_sector[d] = drv_sector[d] + SECTOR_W'(drv_count[d]);
            drv_dma[d]    = drv_dma[d] + DMA_W'(nbytes);
          end else if (r.write_byte == CMD_CLEAR_ERROR) begin
            drv_err[d] = 1'b0;
          end
        end
        default: ;
      endcase
    end
    return o;
  endfunction

  function automatic req_t mk_req(input logic op, input logic [OFF_W-1:0] off,
                                  input logic [BYTE_W-1:0] b, input logic mf);
    req_t r;
    r.opcode     = op;
    r.reg_offset = off;
    r.write_byte = b;
    r.media_fail = mf;
    return r;
  endfunction

  function automatic void plan(input logic op, input logic [OFF_W-1:0] off,
                               input logic [BYTE_W-1:0] b, input logic mf,
                               input bit known, input rsp_t want);
    plan_row_t row;
    row.rq    = mk_req(op, off, b, mf);
    row.known = known;
    row.want  = want;
    directed_plan.push_back(row);
  endfunction

  // Lane byte biased toward all ones so that sector and address wrap happen.
  function automatic logic [BYTE_W-1:0] lane_byte();
    return ($urandom_range(0, 3) == 0) ? 8'hFF : BYTE_W'($urandom);
  endfunction

  // A typical driver sequence: select, program, transfer, read back.
  function automatic void queue_drive_job();
    int                n_cmds;
    logic [BYTE_W-1:0] cnt;
    job_q.push_back(mk_req(OP_WRITE, OFF_STATUS,
                           CMD_SELECT_FIRST | BYTE_W'($urandom_range(0, NDRIVES - 1)),
                           1'($urandom)));
    if ($urandom_range(0, 1) == 0)
      job_q.push_back(mk_req(OP_WRITE, OFF_STATUS,
                             CMD_SIZE_FIRST | BYTE_W'($urandom_range(0, 3)), 1'($urandom)));
    for (int off = OFF_SEC3; off <= OFF_DMA0; off++) begin
      if ($urandom_range(0, 9) < 7)
        job_q.push_back(mk_req(OP_WRITE, OFF_W'(off), lane_byte(), 1'($urandom)));
    end
    case ($urandom_range(0, 9))
      0:       cnt = '0;
      1:       cnt = 8'hFF;
      2, 3, 4: cnt = BYTE_W'($urandom_range(1, 8));
      default: cnt = BYTE_W'($urandom);
    endcase
    job_q.push_back(mk_req(OP_WRITE, OFF_COUNT, cnt, 1'($urandom)));
    n_cmds = $urandom_range(1, 4);
    for (int k = 0; k < n_cmds; k++)
      job_q.push_back(mk_req(OP_WRITE, OFF_STATUS, CMD_READ, $urandom_range(0, 3) == 0));
    n_cmds = $urandom_range(1, 3);
    for (int k = 0; k < n_cmds; k++)
      job_q.push_back(mk_req(OP_READ, OFF_W'($urandom_range(OFF_SEC3, OFF_STATUS)),
                             BYTE_W'($urandom), 1'($urandom)));
    if ($urandom_range(0, 9) < 4)
      job_q.push_back(mk_req(OP_WRITE, OFF_STATUS, CMD_CLEAR_ERROR, 1'($urandom)));
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic offer(input req_t rq, input bit known, input rsp_t want);
    rsp_t predicted;
    in_valid   <= 1'b1;
    opcode     <= rq.opcode;
    reg_offset <= rq.reg_offset;
    write_byte <= rq.write_byte;
    media_fail <= rq.media_fail;
    do @(posedge clk); while (in_stall);
    predicted = disk_regs_access(rq);
    pending_rsp.push_back(known ? want : predicted);
    n_sent++;
  endtask

  task automatic idle(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender burst pacing; no gaps while the receiver holds off.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else if (!long_hold) begin
      idle($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      n_errors++;
    end
  endtask

  // Sender: reset, directed table, then random drive jobs mixed with noise.
  initial begin : sender
    req_t rq;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // After reset, unmapped offsets, a default transfer with a media error.
    plan(OP_READ,  OFF_STATUS, '0, 1'b0, 1'b1, '{read_byte: 8'h60, default: '0});
    plan(OP_READ,  OFF_COUNT,  '0, 1'b0, 1'b1, '{read_byte: 8'h01, default: '0});
    plan(OP_READ,  OFF_UNMAPPED_LAST,  '0,    1'b0, 1'b1, '0);
    plan(OP_WRITE, OFF_UNMAPPED_FIRST, 8'hFF, 1'b1, 1'b1, '0);
    plan(OP_WRITE, OFF_STATUS, CMD_READ, 1'b1, 1'b1,
         '{xfer_valid: 1'b1, xfer_bytes: 18'd512, default: '0});
    plan(OP_READ,  OFF_STATUS, '0, 1'b0, 1'b1, '{read_byte: 8'hE0, default: '0});
    plan(OP_WRITE, OFF_STATUS, CMD_CLEAR_ERROR, 1'b0, 1'b1, '0);
    plan(OP_READ,  OFF_SEC0,   '0, 1'b0, 1'b1, '{read_byte: 8'h01, default: '0});
    // All lanes at their maximum, largest size, largest count.
    plan(OP_WRITE, OFF_SEC3,   8'hFF, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_SEC2,   8'hFF, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_SEC1,   8'hFF, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_SEC0,   8'hFF, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_DMA2,   8'hFF, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_DMA1,   8'hFF, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_DMA0,   8'hFF, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_COUNT,  8'hFF, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_STATUS, CMD_SIZE_LAST, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_STATUS, CMD_READ, 1'b0, 1'b1,
         '{xfer_valid: 1'b1, xfer_sector: 32'hFFFF_FFFF, xfer_dma_addr: 24'hFF_FFFF,
           xfer_bytes: 18'd261120, default: '0});
    plan(OP_READ,  OFF_SEC0,   '0, 1'b0, 1'b0, '0);
    // A zero count issues nothing and leaves the error flag alone.
    plan(OP_WRITE, OFF_COUNT,  8'h00, 1'b0, 1'b0, '0);
    plan(OP_WRITE, OFF_STATUS, CMD_READ, 1'b1, 1'b1, '0);
    plan(OP_READ,  OFF_STATUS, '0, 1'b0, 1'b1, '{read_byte: 8'h70, default: '0});
    // Last drive, then an undefined command.
    plan(OP_WRITE, OFF_STATUS, CMD_SELECT_LAST, 1'b0, 1'b0, '0);
    plan(OP_READ,  OFF_STATUS, '0, 1'b0, 1'b1, '{read_byte: 8'h6F, default: '0});
    plan(OP_WRITE, OFF_STATUS, CMD_UNUSED, 1'b1, 1'b0, '0);

    foreach (directed_plan[i]) begin
      offer(directed_plan[i].rq, directed_plan[i].known, directed_plan[i].want);
      pace();
    end
    drain();

    while (n_random < RANDOM_ITEMS) begin
      if (job_q.size() == 0) begin
        if ($urandom_range(0, 9) < 7)
          queue_drive_job();
        else
          job_q.push_back(mk_req(1'($urandom), OFF_W'($urandom), BYTE_W'($urandom),
                                 1'($urandom)));
      end
      rq = job_q.pop_front();
      offer(rq, 1'b0, '0);
      n_random++;
      if (n_random == 300) hold_wanted <= 1'b1;
      if (n_random == 800)
        drain();
      else
        pace();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d directed, %0d random) with %0d transfer responses seen.",
             n_sent, directed_plan.size(), n_random, n_xfer);
    $display("Response mismatches or unexpected responses: %0d.", n_errors);
    if (n_errors == 0)
      $display("multi_drive_disk_register_block regression: pass");
    else
      $display("multi_drive_disk_register_block regression: fail");
    $finish;
  end

  // Receiver: stall patterns in segments, plus one long hold-off.
  initial begin : receiver
    rx_mode_e mode;
    int       seg_len;
    bit       hold_done;
    hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      mode    = rx_mode_e'($urandom_range(RX_FLOW, RX_MOSTLY_STALLED));
      seg_len = $urandom_range(5, 40);
      if (hold_wanted && !hold_done) begin
        mode      = RX_HOLD;
        seg_len   = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      long_hold <= (mode == RX_HOLD);
      for (int i = 0; i < seg_len; i++) begin
        case (mode)
          RX_FLOW:           out_stall <= 1'b0;
          RX_COIN:           out_stall <= 1'($urandom);
          RX_EVERY_THIRD:    out_stall <= (i % 3 == 0);
          RX_MOSTLY_STALLED: out_stall <= ($urandom_range(0, 3) != 0);
          default:           out_stall <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  // Compare each accepted response with the oldest expectation.
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t ns: unexpected response, expected none, actual byte 0x%0h xfer %0b",
                 $time, read_byte, xfer_valid);
        n_errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (xfer_valid === 1'b1) n_xfer++;
        check_field("read_byte",     32'(want.read_byte),     32'(read_byte));
        check_field("xfer_valid",    32'(want.xfer_valid),    32'(xfer_valid));
        check_field("xfer_sector",   want.xfer_sector,        xfer_sector);
        check_field("xfer_dma_addr", 32'(want.xfer_dma_addr), 32'(xfer_dma_addr));
        check_field("xfer_bytes",    32'(want.xfer_bytes),    32'(xfer_bytes));
      end
    end
  end

  initial begin : watchdog
    #LIMIT_NS;
    $display("multi_drive_disk_register_block regression: fail");
    $finish;
  end

endmodule
